@@ rtl/volume_box_blur_density_top_assert.svh @@
// Assertion macros shared by the RTL of the box blur density block.
`ifndef VOLUME_BOX_BLUR_DENSITY_TOP_ASSERT_SVH
`define VOLUME_BOX_BLUR_DENSITY_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VBBD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VBBD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/vbbd_pkg.sv @@
`timescale 1ns / 1ps

package vbbd_pkg;

   localparam int DIM_W     = 6;
   localparam int COORD_W   = 5;
   localparam int WCOORD_W  = 8;
   localparam int CNT_OUT_W = 7;
   localparam int CNT_MAX   = 127;
   localparam int DENS_W    = 16;
   localparam int FRAC_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_LENGTH = 2'd2;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

endpackage

@@ rtl/volume_box_blur_density_top.sv @@
`timescale 1ns / 1ps

// Binary occupancy volume with a box-filter density query. The volume lives in one
// synchronous memory of MAX_SIDE*MAX_SIDE rows, each row holding the MAX_SIDE cells
// along the third axis. After reset a clearing pass zeroes all MAX_SIDE*MAX_SIDE rows,
// one row per cycle, during which no transaction is accepted; configuration writes
// are taken at any time. The block works on one transaction at a time. A write reads
// its row, sets the bit to the requested value and writes the row back. A query reads
// the W*W rows of the window (W = 2*((KERNEL_SIZE-1)/2)+1), one row per cycle, counts
// the window bits of each row, then divides by KERNEL_SIZE cubed by a multiplication
// with a constant reciprocal. A coordinate outside the configured grid skips the memory
// and returns its error flag. A finished result waits in the output register while the
// next transaction is taken.
module volume_box_blur_density_top #(
   parameter int MAX_SIDE    = 32,
   parameter int KERNEL_SIZE = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [vbbd_pkg::COORD_W-1:0]        req_cell_x,
   input  logic [vbbd_pkg::COORD_W-1:0]        req_cell_y,
   input  logic [vbbd_pkg::COORD_W-1:0]        req_cell_z,
   input  logic                                req_occupied,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [vbbd_pkg::CNT_OUT_W-1:0]      rsp_neighbor_count,
   output logic [vbbd_pkg::DENS_W-1:0]         rsp_density,
   output logic                                rsp_coord_error,
   input  logic                                csr_we,
   input  logic [vbbd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vbbd_pkg::DIM_W-1:0]          csr_wdata
);

   import vbbd_pkg::*;

   localparam int HALF  = (KERNEL_SIZE - 1) / 2;
   localparam int WIN   = 2 * HALF + 1;
   localparam int KCUBE = KERNEL_SIZE * KERNEL_SIZE * KERNEL_SIZE;
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int ZW    = $clog2(MAX_SIDE);
   localparam int DW    = $clog2(WIN + 1);
   localparam int CNTW  = $clog2(WIN * WIN * WIN + 1);
   localparam int CSW   = (CNTW > CNT_OUT_W) ? CNTW : CNT_OUT_W;
   localparam int QW    = CNTW + FRAC_W;
   localparam int LGK   = $clog2(KCUBE);
   localparam int PSH   = QW + LGK;
   localparam int SHR   = PSH - FRAC_W;
   localparam int PW    = SHR + QW;
   localparam int CLIP  = (MAX_SIDE > 63) ? 63 : MAX_SIDE;

   // The reciprocal is rounded up; with PSH = QW + LGK the truncated product equals
   // the exact floor of the quotient for every dividend below 2**QW.
   localparam longint RECIP = ((longint'(1) << PSH) + longint'(KCUBE) - longint'(1))
                              / longint'(KCUBE);

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_DISPATCH = 3'd2;
   localparam logic [2:0] ST_WR_WB    = 3'd3;
   localparam logic [2:0] ST_Q_READ   = 3'd4;
   localparam logic [2:0] ST_Q_LAST   = 3'd5;
   localparam logic [2:0] ST_DIV      = 3'd6;
   localparam logic [2:0] ST_DONE     = 3'd7;

   logic [MAX_SIDE-1:0]        mem [DEPTH];
   logic [MAX_SIDE-1:0]        rd_data_ff;
   logic [MAX_SIDE-1:0]        wr_row;
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [MAX_SIDE-1:0]        mem_wdata;
   logic [AW-1:0]              rd_addr;

   logic [2:0]                 state_ff, state_in;
   logic [AW-1:0]              clr_addr_ff, clr_addr_in;
   logic                       func_ff, func_in;
   logic [COORD_W-1:0]         x_ff, x_in;
   logic [COORD_W-1:0]         y_ff, y_in;
   logic [COORD_W-1:0]         z_ff, z_in;
   logic                       occ_ff, occ_in;
   logic                       bad_ff, bad_in;
   logic [DW-1:0]              di_ff, di_in;
   logic [DW-1:0]              dj_ff, dj_in;
   logic                       acc_vld_ff, acc_vld_in;
   logic                       acc_ok_ff, acc_ok_in;
   logic [CNTW-1:0]            count_ff, count_in;
   logic [QW-1:0]              div_ff, div_in;
   logic [DIM_W-1:0]           width_ff, width_in;
   logic [DIM_W-1:0]           height_ff, height_in;
   logic [DIM_W-1:0]           length_ff, length_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CNT_OUT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic [DENS_W-1:0]          rsp_density_ff, rsp_density_in;
   logic                       rsp_error_ff, rsp_error_in;

   logic [DIM_W-1:0]           dw, dh, dl;
   logic                       bad;
   logic signed [WCOORD_W-1:0] sx, sy, sz, win_i, win_j, rd_i, rd_j;
   logic                       row_ok;
   logic [DW-1:0]              row_pop;
   logic [CNTW-1:0]            count_acc;
   logic [PW-1:0]              prod_full;
   logic [CSW-1:0]             cnt_ext;
   logic                       rsp_zero;

   assign dw = (width_ff  > DIM_W'(CLIP)) ? DIM_W'(CLIP) : width_ff;
   assign dh = (height_ff > DIM_W'(CLIP)) ? DIM_W'(CLIP) : height_ff;
   assign dl = (length_ff > DIM_W'(CLIP)) ? DIM_W'(CLIP) : length_ff;

   assign bad = ({1'b0, x_ff} >= dw) || ({1'b0, y_ff} >= dh) || ({1'b0, z_ff} >= dl);

   assign sx    = $signed(WCOORD_W'(x_ff));
   assign sy    = $signed(WCOORD_W'(y_ff));
   assign sz    = $signed(WCOORD_W'(z_ff));
   assign win_i = sx - $signed(WCOORD_W'(HALF)) + $signed(WCOORD_W'(di_ff));
   assign win_j = sy - $signed(WCOORD_W'(HALF)) + $signed(WCOORD_W'(dj_ff));
   assign rd_i  = (state_ff == ST_Q_READ) ? win_i : sx;
   assign rd_j  = (state_ff == ST_Q_READ) ? win_j : sy;
   assign rd_addr = AW'($unsigned(rd_i)) * AW'(MAX_SIDE) + AW'($unsigned(rd_j));

   assign row_ok = (win_i >= 0) && (win_i < $signed(WCOORD_W'(dw)))
                && (win_j >= 0) && (win_j < $signed(WCOORD_W'(dh)));

   always_comb begin
      logic signed [WCOORD_W-1:0] idx;
      logic                       hit;
      row_pop = '0;
      for (int d = 0; d < WIN; d++) begin
         idx = sz - $signed(WCOORD_W'(HALF)) + $signed(WCOORD_W'(d));
         hit = (idx >= 0) && (idx < $signed(WCOORD_W'(dl))) && rd_data_ff[idx[ZW-1:0]];
         row_pop = row_pop + DW'(hit);
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_SIDE; k++) begin
         wr_row[k] = (k == int'(z_ff)) ? occ_ff : rd_data_ff[k];
      end
   end

   assign count_acc = (acc_vld_ff && acc_ok_ff) ? count_ff + CNTW'(row_pop) : count_ff;
   assign prod_full = PW'(count_ff) * PW'(RECIP);
   assign cnt_ext   = CSW'(count_ff);
   assign rsp_zero  = (rsp_count_ff == '0) && (rsp_density_ff == '0);

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      func_in        = func_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      occ_in         = occ_ff;
      bad_in         = bad_ff;
      di_in          = di_ff;
      dj_in          = dj_ff;
      acc_vld_in     = (state_ff == ST_Q_READ);
      acc_ok_in      = row_ok;
      count_in       = count_acc;
      div_in         = div_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_count_in   = rsp_count_ff;
      rsp_density_in = rsp_density_ff;
      rsp_error_in   = rsp_error_ff;
      mem_we         = 1'b0;
      mem_waddr      = rd_addr;
      mem_wdata      = wr_row;

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               x_in     = req_cell_x;
               y_in     = req_cell_y;
               z_in     = req_cell_z;
               occ_in   = req_occupied;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            bad_in   = bad;
            count_in = '0;
            div_in   = '0;
            di_in    = '0;
            dj_in    = '0;
            if (bad) begin
               state_in = ST_DONE;
            end else if (func_ff == FUNC_WRITE) begin
               state_in = ST_WR_WB;
            end else begin
               state_in = ST_Q_READ;
            end
         end
         ST_WR_WB: begin
            mem_we   = 1'b1;
            state_in = ST_DONE;
         end
         ST_Q_READ: begin
            if (dj_ff == DW'(WIN - 1)) begin
               dj_in = '0;
               di_in = di_ff + DW'(1);
               if (di_ff == DW'(WIN - 1)) begin
                  state_in = ST_Q_LAST;
               end
            end else begin
               dj_in = dj_ff + DW'(1);
            end
         end
         ST_Q_LAST: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            div_in   = prod_full[PW-1:SHR];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_count_in   = (cnt_ext > CSW'(CNT_MAX)) ? CNT_OUT_W'(CNT_MAX)
                                                          : CNT_OUT_W'(cnt_ext);
               rsp_density_in = (div_ff[QW-1:FRAC_W] != '0) ? '1 : div_ff[FRAC_W-1:0];
               rsp_error_in   = bad_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      length_in = length_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GRID_WIDTH:  width_in  = csr_wdata;
            CSR_GRID_HEIGHT: height_in = csr_wdata;
            CSR_GRID_LENGTH: length_in = csr_wdata;
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         acc_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= DIM_RESET;
         height_ff    <= DIM_RESET;
         length_ff    <= DIM_RESET;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         acc_vld_ff   <= acc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         length_ff    <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      z_ff           <= z_in;
      occ_ff         <= occ_in;
      bad_ff         <= bad_in;
      di_ff          <= di_in;
      dj_ff          <= dj_in;
      acc_ok_ff      <= acc_ok_in;
      count_ff       <= count_in;
      div_ff         <= div_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_density_ff <= rsp_density_in;
      rsp_error_ff   <= rsp_error_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_neighbor_count = rsp_count_ff;
   assign rsp_density        = rsp_density_ff;
   assign rsp_coord_error    = rsp_error_ff;

`include "volume_box_blur_density_top_assert.svh"

   `VBBD_ASSERT_SAME(a_error_zero, rsp_valid_ff && rsp_error_ff, rsp_zero, "Error result not zero.")
   `VBBD_ASSERT_NEXT(a_accept, req_valid && req_ready, state_ff == ST_DISPATCH, "Lost accept.")
   `VBBD_ASSERT_NEXT(a_rsp_hold, rsp_valid_ff && !rsp_ready, rsp_valid_ff, "Result dropped.")

endmodule

@@ bench/density_ledger_pkg.sv @@
`timescale 1ns / 1ps

package density_ledger_pkg;
   import vbbd_pkg::*;

   localparam int GRID_SIDE = 32;
   localparam int KERNEL    = 6;
   localparam int HALF_WIN  = (KERNEL - 1) / 2;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic               func;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               occupied;
   } cell_request_type;

   typedef struct packed {
      logic [CNT_OUT_W-1:0] count;
      logic [DENS_W-1:0]    density;
      logic                 coord_error;
   } density_result_type;

   class density_ledger;
      bit              occ_cells [GRID_SIDE*GRID_SIDE*GRID_SIDE];
      logic [DIM_W-1:0] dim_w;
      logic [DIM_W-1:0] dim_h;
      logic [DIM_W-1:0] dim_l;
      density_result_type owed_results [$];
      int              fail_count;

      function new();
         foreach (occ_cells[n]) occ_cells[n] = 1'b0;
         dim_w = DIM_RESET;
         dim_h = DIM_RESET;
         dim_l = DIM_RESET;
         fail_count = 0;
      endfunction

      function void set_dim(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
         case (idx)
            CSR_GRID_WIDTH: dim_w = value;
            CSR_GRID_HEIGHT: dim_h = value;
            CSR_GRID_LENGTH: dim_l = value;
            default: ;
         endcase
      endfunction

      function int owed_count();
         return owed_results.size();
      endfunction

      function void take_request(cell_request_type r);
         int              ew, eh, el, i, j, k;
         int unsigned     hits;
         longint unsigned frac;
         density_result_type res;
         ew = (dim_w > GRID_SIDE) ? GRID_SIDE : int'(dim_w);
         eh = (dim_h > GRID_SIDE) ? GRID_SIDE : int'(dim_h);
         el = (dim_l > GRID_SIDE) ? GRID_SIDE : int'(dim_l);
         res = '0;
         res.coord_error = (int'(r.x) >= ew) || (int'(r.y) >= eh) || (int'(r.z) >= el);
         if (!res.coord_error) begin
            if (r.func == FUNC_WRITE) begin
               occ_cells[(int'(r.x) * GRID_SIDE + int'(r.y)) * GRID_SIDE + int'(r.z)] =
                  r.occupied;
            end else begin
               hits = 0;
               for (i = int'(r.x) - HALF_WIN; i <= int'(r.x) + HALF_WIN; i++)
                  for (j = int'(r.y) - HALF_WIN; j <= int'(r.y) + HALF_WIN; j++)
                     for (k = int'(r.z) - HALF_WIN; k <= int'(r.z) + HALF_WIN; k++)
                        if (i >= 0 && i < ew && j >= 0 && j < eh && k >= 0 && k < el)
                           hits += occ_cells[(i * GRID_SIDE + j) * GRID_SIDE + k];
               frac = 64'(hits);
               frac = (frac << FRAC_W) / (KERNEL * KERNEL * KERNEL);
               if (frac > 64'hFFFF) frac = 64'hFFFF;
               res.count   = CNT_OUT_W'((hits > CNT_MAX) ? CNT_MAX : hits);
               res.density = frac[DENS_W-1:0];
            end
         end
         owed_results.push_back(res);
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         fail_count++;
      endtask

      task check_result(density_result_type got);
         density_result_type want;
         if (owed_results.size() == 0) begin
            report($sformatf("result with nothing pending: count=%0d density=%0d error=%0b",
                             got.count, got.density, got.coord_error));
            return;
         end
         want = owed_results.pop_front();
         if (got.count !== want.count)
            report($sformatf("neighbor_count got %0d, want %0d", got.count, want.count));
         if (got.density !== want.density)
            report($sformatf("density got %0d, want %0d", got.density, want.density));
         if (got.coord_error !== want.coord_error)
            report($sformatf("coord_error got %0b, want %0b", got.coord_error,
                             want.coord_error));
      endtask
   endclass

endpackage

@@ bench/tb_volume_box_blur_density_top.sv @@
`timescale 1ns / 1ps

module tb_volume_box_blur_density_top;
   import vbbd_pkg::*;
   import density_ledger_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_func;
   logic [COORD_W-1:0]   req_cell_x;
   logic [COORD_W-1:0]   req_cell_y;
   logic [COORD_W-1:0]   req_cell_z;
   logic                 req_occupied;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [CNT_OUT_W-1:0] rsp_neighbor_count;
   logic [DENS_W-1:0]    rsp_density;
   logic                 rsp_coord_error;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_wdata;

   density_ledger sb;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   bit            hold_rsp = 1'b0;

   volume_box_blur_density_top #(
      .MAX_SIDE(GRID_SIDE),
      .KERNEL_SIZE(KERNEL)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_cell_x(req_cell_x),
      .req_cell_y(req_cell_y),
      .req_cell_z(req_cell_z),
      .req_occupied(req_occupied),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_neighbor_count(rsp_neighbor_count),
      .rsp_density(rsp_density),
      .rsp_coord_error(rsp_coord_error),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // The long hold-off lets the block fill up and stall its input side.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready = 1'b0;
            repeat (400) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      density_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.count       = rsp_neighbor_count;
         got.density     = rsp_density;
         got.coord_error = rsp_coord_error;
         sb.check_result(got);
      end
   end

   task automatic send_item(input logic func, input int x, input int y, input int z,
                            input logic occ);
      cell_request_type r;
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid    = 1'b1;
      req_func     = func;
      req_cell_x   = x[COORD_W-1:0];
      req_cell_y   = y[COORD_W-1:0];
      req_cell_z   = z[COORD_W-1:0];
      req_occupied = occ;
      do @(posedge clock); while (!req_ready);
      r = '{func, req_cell_x, req_cell_y, req_cell_z, occ};
      sb.take_request(r);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value[DIM_W-1:0];
      @(negedge clock);
      csr_we = 1'b0;
      sb.set_dim(idx, value[DIM_W-1:0]);
   endtask

   task automatic wait_drained();
      while (sb.owed_count() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic int clip_coord(int v);
      return (v < 0) ? 0 : (v > GRID_SIDE - 1) ? GRID_SIDE - 1 : v;
   endfunction

   initial begin
      int dim_plan [9][3];
      int s, n, i, j, k, roll, ew, eh, el, cx, cy, cz;
      sb = new();
      dim_plan = '{'{32, 32, 32}, '{63, 63, 63}, '{4, 9, 2}, '{1, 32, 17}, '{32, 32, 32},
                   '{0, 20, 20}, '{31, 30, 29}, '{32, 32, 32}, '{32, 32, 32}};
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_func     = FUNC_WRITE;
      req_cell_x   = '0;
      req_cell_y   = '0;
      req_cell_z   = '0;
      req_occupied = 1'b0;
      csr_we       = 1'b0;
      csr_index    = CSR_GRID_WIDTH;
      csr_wdata    = DIM_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 38;
      recv_idle_pct = 86;
      send_item(FUNC_WRITE, 0, 0, 0, 1'b1);
      send_item(FUNC_WRITE, 31, 31, 31, 1'b1);
      send_item(FUNC_WRITE, 2, 2, 2, 1'b1);
      send_item(FUNC_WRITE, 31, 0, 31, 1'b1);
      send_item(FUNC_QUERY, 0, 0, 0, 1'b1);
      send_item(FUNC_QUERY, 31, 31, 31, 1'b0);
      send_item(FUNC_QUERY, 2, 2, 2, 1'b0);
      send_item(FUNC_QUERY, 30, 1, 30, 1'b0);
      send_item(FUNC_WRITE, 0, 0, 0, 1'b0);
      send_item(FUNC_QUERY, 1, 1, 1, 1'b0);
      send_item(FUNC_QUERY, 16, 16, 16, 1'b0);
      wait_drained();
      write_csr(CSR_GRID_WIDTH, 1);
      write_csr(CSR_GRID_HEIGHT, 63);
      send_item(FUNC_WRITE, 0, 5, 5, 1'b1);
      send_item(FUNC_WRITE, 1, 5, 5, 1'b1);
      send_item(FUNC_QUERY, 1, 5, 5, 1'b0);
      send_item(FUNC_QUERY, 0, 5, 5, 1'b0);
      wait_drained();
      write_csr(CSR_GRID_HEIGHT, 0);
      send_item(FUNC_QUERY, 0, 0, 0, 1'b0);
      send_item(FUNC_WRITE, 0, 3, 3, 1'b1);
      wait_drained();
      write_csr(CSR_GRID_WIDTH, 32);
      write_csr(CSR_GRID_HEIGHT, 32);
      write_csr(CSR_GRID_LENGTH, 1);
      send_item(FUNC_QUERY, 1, 4, 0, 1'b0);
      send_item(FUNC_QUERY, 0, 3, 3, 1'b0);
      wait_drained();
      write_csr(CSR_GRID_LENGTH, 32);
      write_csr(CSR_UNUSED, 5);
      send_item(FUNC_QUERY, 0, 5, 5, 1'b0);
      send_item(FUNC_QUERY, 1, 5, 5, 1'b0);

      for (s = 0; s < 9; s++) begin
         wait_drained();
         case (s / 3)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 86;
            end
            1: begin
               send_idle_pct = 86;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (s == 7) begin
            dim_plan[s][0] = $urandom_range(40, 1);
            dim_plan[s][1] = $urandom_range(40, 1);
            dim_plan[s][2] = $urandom_range(40, 1);
         end
         write_csr(CSR_GRID_WIDTH, dim_plan[s][0]);
         write_csr(CSR_GRID_HEIGHT, dim_plan[s][1]);
         write_csr(CSR_GRID_LENGTH, dim_plan[s][2]);
         ew = (dim_plan[s][0] > GRID_SIDE) ? GRID_SIDE : dim_plan[s][0];
         eh = (dim_plan[s][1] > GRID_SIDE) ? GRID_SIDE : dim_plan[s][1];
         el = (dim_plan[s][2] > GRID_SIDE) ? GRID_SIDE : dim_plan[s][2];
         if (s == 4) hold_rsp = 1'b1;
         if (s == 8) begin
            // A fully occupied window gives the largest count and density.
            cx = $urandom_range(29, 2);
            cy = $urandom_range(29, 2);
            cz = $urandom_range(29, 2);
            for (i = -HALF_WIN; i <= HALF_WIN; i++)
               for (j = -HALF_WIN; j <= HALF_WIN; j++)
                  for (k = -HALF_WIN; k <= HALF_WIN; k++)
                     send_item(FUNC_WRITE, cx + i, cy + j, cz + k, 1'b1);
            send_item(FUNC_QUERY, cx, cy, cz, 1'b0);
            repeat (4)
               send_item(FUNC_QUERY, clip_coord(cx + int'($urandom_range(6)) - 3),
                         clip_coord(cy + int'($urandom_range(6)) - 3),
                         clip_coord(cz + int'($urandom_range(6)) - 3), 1'b1);
         end
         cx = (ew == 0) ? $urandom_range(31) : $urandom_range(ew - 1);
         cy = (eh == 0) ? $urandom_range(31) : $urandom_range(eh - 1);
         cz = (el == 0) ? $urandom_range(31) : $urandom_range(el - 1);
         for (n = 0; n < 45; n++) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
               send_item(logic'($urandom_range(1)), $urandom_range(31), $urandom_range(31),
                         $urandom_range(31), logic'($urandom_range(1)));
            end else begin
               if (roll < 20) begin
                  cx = (ew == 0) ? $urandom_range(31) : $urandom_range(ew - 1);
                  cy = (eh == 0) ? $urandom_range(31) : $urandom_range(eh - 1);
                  cz = (el == 0) ? $urandom_range(31) : $urandom_range(el - 1);
               end
               i = clip_coord(cx + int'($urandom_range(6)) - 3);
               j = clip_coord(cy + int'($urandom_range(6)) - 3);
               k = clip_coord(cz + int'($urandom_range(6)) - 3);
               if ($urandom_range(99) < 60)
                  send_item(FUNC_WRITE, i, j, k, $urandom_range(99) < 85);
               else
                  send_item(FUNC_QUERY, i, j, k, logic'($urandom_range(1)));
            end
         end
      end

      wait_drained();
      repeat (60) @(negedge clock);
      if (sb.owed_count() != 0)
         sb.report($sformatf("%0d results never arrived", sb.owed_count()));
      if (sb.fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
